>>> src/fmod_pkg.sv
// ----------------------------------------------------------------------------
// fmod_pkg
// Shared constants and controller/datapath types for the single-precision
// truncated remainder block.
// ----------------------------------------------------------------------------
package fmod_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SigW  = 24;
  localparam int unsigned ExpW  = 10;

  localparam logic [WordW-1:0] SignMask  = 32'h8000_0000;
  localparam logic [WordW-1:0] AbsMask   = 32'h7fff_ffff;
  localparam logic [WordW-1:0] InfBits   = 32'h7f80_0000;
  localparam logic [WordW-1:0] HiddenBit = 32'h0080_0000;
  localparam logic [WordW-1:0] FracMask  = 32'h007f_ffff;
  localparam logic [WordW-1:0] QnanBits  = 32'h7fc0_0000;

  localparam logic signed [ExpW-1:0] MinNormExp = -10'sd126;
  localparam logic signed [ExpW-1:0] ExpBias    = 10'sd127;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic norm_op;
    logic red_step;
    logic red_final;
    logic norm_res;
    logic pack;
  } fmod_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;
    logic ops_norm;
    logic ex_gt_ey;
    logic res_zero;
    logic res_norm;
  } fmod_sts_t;

endpackage

>>> src/fmod_if.sv
// ----------------------------------------------------------------------------
// fmod channel interfaces
// Valid/ready channels for the operand pair and for the remainder.
// ----------------------------------------------------------------------------
interface fmod_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] dividend_bits;
  logic [31:0] divisor_bits;

  modport source (output valid, output dividend_bits, output divisor_bits, input ready);
  modport sink   (input valid, input dividend_bits, input divisor_bits, output ready);
endinterface

interface fmod_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] remainder_bits;

  modport source (output valid, output remainder_bits, input ready);
  modport sink   (input valid, input remainder_bits, output ready);
endinterface

>>> src/float32_remainder_fmod_top.sv
// ----------------------------------------------------------------------------
// float32_remainder_fmod_top
// Single-precision fmod: one transaction of x and y in, one remainder out.
// ----------------------------------------------------------------------------
// One transaction at a time. NaN, zero, infinity and |x| <= |y| cases go
// from the operand check straight to the pack step. Otherwise subnormal
// operands are normalized, the exponent difference ex - ey (up to 276) is
// walked by the single shared subtractor, one quotient bit per cycle, and
// the result is normalized before it is packed. The remainder sits in an
// output register, so a new transaction is taken while the last result
// still waits.
// ----------------------------------------------------------------------------
module float32_remainder_fmod_top
  import fmod_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fmod_req_if.sink    req_i,
  fmod_rsp_if.source  rsp_o
);

  fmod_cmd_t cmd;
  fmod_sts_t sts;

  fmod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmod_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dividend_i (req_i.dividend_bits),
    .divisor_i  (req_i.divisor_bits),
    .sts_o      (sts),
    .result_o   (rsp_o.remainder_bits)
  );

`ifndef NO_ASSERTIONS
  // the sequencer is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("input ready right after a transaction");

  // a remainder can never be an infinity
  a_no_inf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.remainder_bits[30:0] != 31'h7f80_0000))
    else $error("infinite remainder produced");

  // a result only appears once a packed value was written
  a_valid_from_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.pack))
    else $error("result valid without a pack step");
`endif

endmodule

>>> src/fmod_ctrl.sv
// ----------------------------------------------------------------------------
// fmod_ctrl
// Sequencer: operand normalize, shift-subtract loop, result normalize, pack.
// ----------------------------------------------------------------------------
module fmod_ctrl
  import fmod_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  fmod_sts_t sts_i,
  output fmod_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_NORM_OP = 5'b00010,
    S_REDUCE  = 5'b00100,
    S_NORM_R  = 5'b01000,
    S_PACK    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NORM_OP;
        end
      end
      S_NORM_OP: begin
        priority if (sts_i.special) begin
          state_d = S_PACK;
        end else if (sts_i.ops_norm) begin
          state_d = S_REDUCE;
        end else begin
          cmd_o.norm_op = 1'b1;
        end
      end
      S_REDUCE: begin
        if (sts_i.ex_gt_ey) begin
          cmd_o.red_step = 1'b1;
        end else begin
          cmd_o.red_final = 1'b1;
          state_d         = S_NORM_R;
        end
      end
      S_NORM_R: begin
        if (sts_i.res_zero || sts_i.res_norm) begin
          state_d = S_PACK;
        end else begin
          cmd_o.norm_res = 1'b1;
        end
      end
      S_PACK: begin
        // wait until the output register is free
        if (out_free) begin
          cmd_o.pack  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/fmod_dp.sv
// ----------------------------------------------------------------------------
// fmod_dp
// Datapath: special-case classify, significand/exponent registers, one
// shared subtractor for the remainder loop, and the result packer.
// ----------------------------------------------------------------------------
module fmod_dp
  import fmod_pkg::*;
(
  input  logic             clk_i,
  input  fmod_cmd_t        cmd_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output fmod_sts_t        sts_o,
  output logic [WordW-1:0] result_o
);

  logic                   sx_q, sx_d;
  logic                   special_q, special_d;
  logic [WordW-1:0]       spec_q, spec_d;
  logic [SigW:0]          mx_q, mx_d;
  logic [SigW-1:0]        my_q, my_d;
  logic signed [ExpW-1:0] ex_q, ex_d, ey_q, ey_d;
  logic [WordW-1:0]       res_q, res_d;

  logic [WordW-1:0]       ax, ay;
  logic [SigW:0]          my_ext, diff, rem;
  logic                   ge;
  logic signed [ExpW-1:0] sh;
  logic [SigW-1:0]        sub_sig;
  logic signed [ExpW-1:0] biased;

  assign ax = dividend_i & AbsMask;
  assign ay = divisor_i & AbsMask;

  // special cases in priority order
  always_comb begin
    special_d = 1'b1;
    spec_d    = dividend_i;
    priority if (ax > InfBits) begin
      spec_d = dividend_i;
    end else if (ay > InfBits) begin
      spec_d = divisor_i;
    end else if (ay == '0 || ax == InfBits) begin
      spec_d = QnanBits;
    end else if (ay == InfBits || ax == '0 || ax < ay) begin
      spec_d = dividend_i;
    end else if (ax == ay) begin
      spec_d = dividend_i & SignMask;
    end else begin
      special_d = 1'b0;
    end
  end

  assign my_ext = {1'b0, my_q};
  assign ge     = (mx_q >= my_ext);
  assign diff   = mx_q - my_ext;
  assign rem    = ge ? diff : mx_q;

  assign sh      = MinNormExp - ex_q;
  assign sub_sig = mx_q[SigW-1:0] >> unsigned'(sh);
  assign biased  = ex_q + ExpBias;

  always_comb begin
    sx_d  = sx_q;
    mx_d  = mx_q;
    my_d  = my_q;
    ex_d  = ex_q;
    ey_d  = ey_q;
    res_d = res_q;
    if (cmd_i.load) begin
      sx_d = dividend_i[WordW-1];
      if (ax < HiddenBit) begin
        mx_d = (SigW+1)'(ax[SigW-2:0]);
        ex_d = MinNormExp;
      end else begin
        mx_d = (SigW+1)'((ax & FracMask) | HiddenBit);
        ex_d = signed'({2'b00, ax[30:23]}) - ExpBias;
      end
      if (ay < HiddenBit) begin
        my_d = SigW'(ay[SigW-2:0]);
        ey_d = MinNormExp;
      end else begin
        my_d = SigW'((ay & FracMask) | HiddenBit);
        ey_d = signed'({2'b00, ay[30:23]}) - ExpBias;
      end
    end
    if (cmd_i.norm_op) begin
      if (!mx_q[SigW-1]) begin
        mx_d = {mx_q[SigW-1:0], 1'b0};
        ex_d = ex_q - 10'sd1;
      end
      if (!my_q[SigW-1]) begin
        my_d = {my_q[SigW-2:0], 1'b0};
        ey_d = ey_q - 10'sd1;
      end
    end
    if (cmd_i.red_step) begin
      mx_d = {rem[SigW-1:0], 1'b0};
      ex_d = ex_q - 10'sd1;
    end
    if (cmd_i.red_final) begin
      mx_d = rem;
    end
    if (cmd_i.norm_res) begin
      mx_d = {mx_q[SigW-1:0], 1'b0};
      ex_d = ex_q - 10'sd1;
    end
    if (cmd_i.pack) begin
      priority if (special_q) begin
        res_d = spec_q;
      end else if (mx_q == '0) begin
        res_d = {sx_q, 31'd0};
      end else if (ex_q > MinNormExp - 10'sd1) begin
        res_d = {sx_q, biased[7:0], mx_q[SigW-2:0]};
      end else begin
        // subnormal result, shift never drops a set bit
        res_d = {sx_q, 7'd0, sub_sig};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      special_q <= special_d;
      spec_q    <= spec_d;
    end
    sx_q  <= sx_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    ex_q  <= ex_d;
    ey_q  <= ey_d;
    res_q <= res_d;
  end

  assign sts_o.special  = special_q;
  assign sts_o.ops_norm = mx_q[SigW-1] && my_q[SigW-1];
  assign sts_o.ex_gt_ey = (ex_q > ey_q);
  assign sts_o.res_zero = (mx_q == '0);
  assign sts_o.res_norm = mx_q[SigW-1];
  assign result_o       = res_q;

endmodule
